// ----- rtl/core/calendar_date_day_stepper_top_macros.svh -----
//------------------------------------------------------------------------------
// Calendar date day stepper assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
//------------------------------------------------------------------------------
`ifndef CALENDAR_DATE_DAY_STEPPER_TOP_MACROS_SVH
`define CALENDAR_DATE_DAY_STEPPER_TOP_MACROS_SVH

// cond must hold at every edge
`define CDDS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons must hold in the cycle after ante
`define CDDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/cdds_pkg.sv -----
//------------------------------------------------------------------------------
// Calendar date day stepper package
// Request types, calendar constants and the month length table.
//------------------------------------------------------------------------------
package cdds_pkg;

  localparam int unsigned YEAR_BITS_DEF = 16;
  localparam int unsigned YEAR_RESET    = 2000;

  localparam logic [4:0] DAY_FIRST  = 5'd1;
  localparam logic [4:0] DAY_LAST   = 5'd31;
  localparam logic [3:0] MONTH_JAN  = 4'd1;
  localparam logic [3:0] MONTH_FEB  = 4'd2;
  localparam logic [3:0] MONTH_DEC  = 4'd12;
  localparam logic [4:0] FEB_LEAP   = 5'd29;

  localparam logic       ACT_SET    = 1'b0;
  localparam logic       ACT_ADD    = 1'b1;

  // days per month, common year; unused codes read as 31
  localparam logic [4:0] MONTH_DAYS [0:15] = '{
    5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
  };

  typedef struct packed {
    logic               action;
    logic [5:0]         new_day;
    logic [3:0]         new_month;
    logic [15:0]        new_year;
    logic signed [15:0] day_count;
  } in_req_t;

  typedef struct packed {
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [15:0] out_year;
  } out_req_t;

  typedef struct packed {
    logic [4:0] day;
    logic [3:0] month;
  } dm_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_EMIT
  } state_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    len = MONTH_DAYS[month];
    if (month == MONTH_FEB && leap) begin
      len = FEB_LEAP;
    end
    return len;
  endfunction

endpackage

// ----- rtl/core/calendar_date_day_stepper_top.sv -----
//------------------------------------------------------------------------------
// Calendar date day stepper
// Keeps a day, month and year; set requests load it, add requests move it by
// a signed day count, one day per cycle through a shared step unit.
//------------------------------------------------------------------------------
// A set request goes from ST_IDLE through ST_STEP to ST_EMIT; an add request
// of count N moves the date |N| days in ST_STEP (up to 32768 for -32768); the
// single day step unit is used once per cycle. One request is in work at a
// time; the result register lets a new request enter while a result waits.
module calendar_date_day_stepper_top #(
  parameter int unsigned YEAR_BITS = cdds_pkg::YEAR_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cdds_pkg::in_req_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output cdds_pkg::out_req_t out_data
);
  import cdds_pkg::*;

  state_t               state_r,   state_nxt;
  dm_t                  dm_r,      dm_nxt;
  logic [YEAR_BITS-1:0] year_r,    year_nxt;
  logic [15:0]          cnt_r,     cnt_nxt;
  logic                 back_r,    back_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_req_t             out_data_r,  out_data_nxt;

  dm_t                  step_dm;
  logic [YEAR_BITS-1:0] step_year;
  logic                 in_acc;
  logic                 out_free;

  cdds_day_step #(
    .YEAR_BITS (YEAR_BITS)
  ) u_step (
    .dm_i   (dm_r),
    .year_i (year_r),
    .back_i (back_r),
    .dm_o   (step_dm),
    .year_o (step_year)
  );

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (cnt_r == 16'd0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = (state_r != ST_IDLE);
    dm_nxt        = dm_r;
    year_nxt      = year_r;
    cnt_nxt       = cnt_r;
    back_nxt      = back_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.action == ACT_SET) begin
            cnt_nxt = 16'd0;
            if (in_data.new_day != 6'd0 && in_data.new_day <= 6'(DAY_LAST)) begin
              dm_nxt.day = in_data.new_day[4:0];
            end
            if (in_data.new_month != 4'd0 && in_data.new_month <= MONTH_DEC) begin
              dm_nxt.month = in_data.new_month;
            end
            if (in_data.new_year != 16'd0) begin
              year_nxt = YEAR_BITS'(in_data.new_year);
            end
          end else begin
            back_nxt = in_data.day_count[15];
            cnt_nxt  = in_data.day_count[15] ? (16'd0 - in_data.day_count)
                                             : in_data.day_count;
          end
        end
      end
      ST_STEP: begin
        if (cnt_r != 16'd0) begin
          dm_nxt   = step_dm;
          year_nxt = step_year;
          cnt_nxt  = cnt_r - 16'd1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.out_day   = dm_r.day;
          out_data_nxt.out_month = dm_r.month;
          out_data_nxt.out_year  = 16'(year_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dm_r.day    <= DAY_FIRST;
      dm_r.month  <= MONTH_JAN;
      year_r      <= YEAR_BITS'(YEAR_RESET);
      cnt_r       <= 16'd0;
      back_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dm_r        <= dm_nxt;
      year_r      <= year_nxt;
      cnt_r       <= cnt_nxt;
      back_r      <= back_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "calendar_date_day_stepper_top_macros.svh"

  `CDDS_ASSERT_ALWAYS(a_date_legal, dm_r.day != 5'd0 && dm_r.month != 4'd0 && dm_r.month <= MONTH_DEC, "stored date out of range")
  `CDDS_ASSERT_ALWAYS(a_idle_cnt, state_r != ST_IDLE || cnt_r == 16'd0, "idle with days left")
  `CDDS_ASSERT_NEXT(a_cnt_dec, state_r == ST_STEP && cnt_r != 16'd0, cnt_r == $past(cnt_r) - 16'd1, "day count not stepped")
  `CDDS_ASSERT_NEXT(a_acc_step, in_acc, state_r == ST_STEP, "request not started")

endmodule

// ----- rtl/core/cdds_day_step.sv -----
//------------------------------------------------------------------------------
// Calendar date single day step
// Moves a date one day forward or backward with month and year rollover.
//------------------------------------------------------------------------------
module cdds_day_step #(
  parameter int unsigned YEAR_BITS = cdds_pkg::YEAR_BITS_DEF
) (
  input  cdds_pkg::dm_t        dm_i,
  input  logic [YEAR_BITS-1:0] year_i,
  input  logic                 back_i,
  output cdds_pkg::dm_t        dm_o,
  output logic [YEAR_BITS-1:0] year_o
);
  import cdds_pkg::*;

  logic       leap;
  logic [4:0] len_cur;
  logic [4:0] len_prev;
  logic [3:0] month_prev;

  assign leap       = (year_i[1:0] == 2'b00);
  assign month_prev = dm_i.month - 4'd1;
  assign len_cur    = month_len(dm_i.month, leap);
  assign len_prev   = month_len(month_prev, leap);

  always_comb begin
    dm_o   = dm_i;
    year_o = year_i;
    if (!back_i) begin
      if (dm_i.day < len_cur) begin
        dm_o.day = dm_i.day + 5'd1;
      end else if (dm_i.month < MONTH_DEC) begin
        dm_o.month = dm_i.month + 4'd1;
        dm_o.day   = DAY_FIRST;
      end else begin
        year_o     = year_i + YEAR_BITS'(1);
        dm_o.month = MONTH_JAN;
        dm_o.day   = DAY_FIRST;
      end
    end else begin
      if (dm_i.day > DAY_FIRST) begin
        dm_o.day = dm_i.day - 5'd1;
      end else if (dm_i.month > MONTH_JAN) begin
        dm_o.month = month_prev;
        dm_o.day   = len_prev;
      end else begin
        year_o     = year_i - YEAR_BITS'(1);
        dm_o.month = MONTH_DEC;
        dm_o.day   = DAY_LAST;
      end
    end
  end

endmodule

// ----- bench/testbench.sv -----
//------------------------------------------------------------------------------
// Calendar date day stepper testbench
// Sends set and add requests with random gaps and output stalls. A scoreboard
// tracks the date and checks every returned date field by field.
//------------------------------------------------------------------------------
module testbench;
  import cdds_pkg::*;

  localparam int unsigned RANDOM_REQS    = 80;
  localparam int unsigned BURST_FIRST    = 30;
  localparam int unsigned BURST_LAST     = 55;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned WATCHDOG_LIMIT = 150000;
  localparam int unsigned MAX_IDLE       = 10;

  localparam logic [3:0] MONTH_MAR  = 4'd3;
  localparam logic [3:0] MONTH_APR  = 4'd4;
  localparam logic [3:0] MONTH_JUN  = 4'd6;
  localparam logic [3:0] MONTH_SEP  = 4'd9;
  localparam logic [3:0] MONTH_NOV  = 4'd11;
  localparam logic [4:0] FEB_COMMON = 5'd28;

  class calendar_scoreboard;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    out_req_t    expected_dates[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned sets;
    int unsigned adds;

    function new();
      day        = DAY_FIRST;
      month      = MONTH_JAN;
      year       = 16'(YEAR_RESET);
      mismatches = 0;
      checked    = 0;
      sets       = 0;
      adds       = 0;
    endfunction

    function logic [4:0] month_length();
      case (month)
        MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 5'd30;
        MONTH_FEB: return (year[1:0] == 2'b00) ? FEB_LEAP : FEB_COMMON;
        default: return DAY_LAST;
      endcase
    endfunction

    function void advance_day();
      if (day < month_length()) begin
        day++;
      end else if (month < MONTH_DEC) begin
        month++;
        day = DAY_FIRST;
      end else begin
        year++;
        month = MONTH_JAN;
        day   = DAY_FIRST;
      end
    endfunction

    function void retreat_day();
      if (day > DAY_FIRST) begin
        day--;
      end else if (month > MONTH_JAN) begin
        month--;
        day = month_length();
      end else begin
        year--;
        month = MONTH_DEC;
        day   = DAY_LAST;
      end
    endfunction

    function void apply_request(input in_req_t r);
      int steps;
      if (r.action == ACT_SET) begin
        sets++;
        if (r.new_day >= 6'(DAY_FIRST) && r.new_day <= 6'(DAY_LAST)) begin
          day = r.new_day[4:0];
        end
        if (r.new_month >= MONTH_JAN && r.new_month <= MONTH_DEC) begin
          month = r.new_month;
        end
        if (r.new_year != 16'd0) begin
          year = r.new_year;
        end
      end else begin
        adds++;
        steps = int'($signed(r.day_count));
        for (; steps > 0; steps--) advance_day();
        for (; steps < 0; steps++) retreat_day();
      end
      expected_dates.push_back('{out_day: day, out_month: month, out_year: year});
    endfunction

    function void field_check(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void compare_date(input out_req_t got);
      out_req_t want;
      if (expected_dates.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d-%0d-%0d",
                 $time, got.out_year, got.out_month, got.out_day);
        mismatches++;
        return;
      end
      want = expected_dates.pop_front();
      checked++;
      field_check("day", 32'(want.out_day), 32'(got.out_day));
      field_check("month", 32'(want.out_month), 32'(got.out_month));
      field_check("year", 32'(want.out_year), 32'(got.out_year));
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_stall;
  out_req_t out_data;
  logic     burst_mode;

  calendar_scoreboard sb;

  calendar_date_day_stepper_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic in_req_t set_req(input int d, input int m, input int y);
    in_req_t r;
    r.action    = ACT_SET;
    r.new_day   = 6'(d);
    r.new_month = 4'(m);
    r.new_year  = 16'(y);
    r.day_count = 16'($urandom);
    return r;
  endfunction

  function automatic in_req_t add_req(input int count);
    in_req_t r;
    r.action    = ACT_ADD;
    r.new_day   = 6'($urandom);
    r.new_month = 4'($urandom);
    r.new_year  = 16'($urandom);
    r.day_count = 16'(count);
    return r;
  endfunction

  function automatic in_req_t random_request();
    in_req_t     r;
    int unsigned pick;
    r = add_req($urandom);
    if ($urandom_range(0, 9) < 4) begin
      r.action = ACT_SET;
      if ($urandom_range(0, 9) < 8) r.new_day = 6'($urandom_range(DAY_FIRST, DAY_LAST));
      if ($urandom_range(0, 9) < 8) r.new_month = 4'($urandom_range(MONTH_JAN, MONTH_DEC));
      pick = $urandom_range(0, 9);
      if (pick == 0) r.new_year = '0;
      else if (pick == 1) r.new_year = '1;
    end else begin
      // mostly short moves; a few full-range counts keep the run bounded
      pick = $urandom_range(0, 99);
      if (pick < 10) r.day_count = 16'(int'($urandom_range(0, 2)) - 1);
      else if (pick < 65) r.day_count = 16'(int'($urandom_range(0, 800)) - 400);
      else if (pick < 94) r.day_count = 16'(int'($urandom_range(0, 6000)) - 3000);
    end
    return r;
  endfunction

  task automatic send_request(input in_req_t req, input bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk iff !in_stall);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.apply_request(in_data);
      if (out_valid && !out_stall) sb.compare_date(out_data);
    end
  end

  initial begin : result_sink
    int unsigned pause;
    bit          held_off;
    held_off = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (burst_mode && !held_off) begin
          // long hold so the block backs up into its input
          pause    = HOLD_CYCLES;
          held_off = 1'b1;
        end else if (burst_mode) begin
          pause = 0;
        end else begin
          pause = $urandom_range(0, MAX_IDLE);
        end
        if (pause > 0) begin
          out_stall <= 1'b1;
          repeat (pause) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, quiet);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : stimulus
    in_req_t directed[$];
    in_req_t req;
    sb = new();
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    burst_mode <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(add_req(0));                  // reset date, zero count
    directed.push_back(set_req(31, 12, 65535));
    directed.push_back(add_req(1));                  // forward year wrap to 0
    directed.push_back(add_req(59));                 // leap day in year zero
    directed.push_back(add_req(-60));                // backward wrap to top year
    directed.push_back(set_req(0, 0, 0));            // nothing loads
    directed.push_back(set_req(63, 15, 0));
    directed.push_back(set_req(32, 13, 2001));       // only the year loads
    directed.push_back(set_req(31, MONTH_FEB, 2001));
    directed.push_back(add_req(1));                  // day past month end
    directed.push_back(set_req(31, MONTH_FEB, 2001));
    directed.push_back(add_req(-1));
    directed.push_back(set_req(30, MONTH_APR, 2024));
    directed.push_back(add_req(1));
    directed.push_back(set_req(1, MONTH_MAR, 2004));
    directed.push_back(add_req(-1));
    directed.push_back(set_req(1, MONTH_MAR, 2003));
    directed.push_back(add_req(-1));
    directed.push_back(set_req(1, MONTH_JAN, 1));
    directed.push_back(add_req(32767));
    directed.push_back(add_req(-32768));
    directed.push_back(set_req(15, MONTH_JUN, 1999));
    directed.push_back(add_req(-400));
    foreach (directed[i]) send_request(directed[i], 1'b0);

    for (int unsigned n = 0; n < RANDOM_REQS; n++) begin
      burst_mode <= (n >= BURST_FIRST && n <= BURST_LAST);
      req = random_request();
      if (n + 1 >= BURST_FIRST && n <= BURST_LAST) begin
        // short moves so the hold backs the block up
        req.day_count = 16'(int'($urandom_range(0, 40)) - 20);
      end
      send_request(req,
                   (n >= BURST_FIRST && n <= BURST_LAST) || ($urandom_range(0, 4) == 0));
    end
    in_valid   <= 1'b0;
    burst_mode <= 1'b0;

    while (sb.expected_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d set and %0d add requests, %0d dates checked, %0d mismatches.",
             sb.sets, sb.adds, sb.checked, sb.mismatches);
    $display("Included year wrap both ways, leap day in year zero and ignored set fields.");
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
